// File: design/msort_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package msort_pkg;

  // data and buffer sizing
  localparam int unsigned DataW          = 32;
  localparam int unsigned MaxElementsDef = 64;
  localparam int unsigned QueueDepthDef  = 2;

  // one classified item in the queue between the front and the back
  typedef struct packed {
    logic [DataW-1:0] value;
    logic             last;
  } q_item_t;

  // back end sequencer states
  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_SETUP     = 5'b00010,
    ST_MERGE     = 5'b00100,
    ST_OUT_FETCH = 5'b01000,
    ST_OUT_SHOW  = 5'b10000
  } back_state_e;

endpackage
`default_nettype wire

// File: design/msort_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module msort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

// File: design/msort_front.sv
`timescale 1ns / 1ps
`default_nettype none
module msort_front #(
  parameter int unsigned MAX_ELEMENTS = msort_pkg::MaxElementsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [msort_pkg::DataW-1:0] value_i,
  input  wire logic                           is_last_i,
  output logic                                push_o,
  output msort_pkg::q_item_t                  item_o,
  input  wire logic                           q_ready_i
);

  import msort_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ELEMENTS);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            last_cls;

  // an item that fills the buffer closes the sequence
  assign last_cls   = is_last_i || (cnt_q == CntW'(MAX_ELEMENTS - 1));
  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;
  assign item_o     = '{value: value_i, last: last_cls};

  // position within the current sequence
  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      cnt_d = last_cls ? '0 : cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// File: design/msort_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module msort_queue #(
  parameter int unsigned DEPTH = msort_pkg::QueueDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  msort_pkg::q_item_t      item_i,
  output logic                    ready_o,
  output logic                    valid_o,
  output msort_pkg::q_item_t      item_o,
  input  wire logic               pop_i
);

  import msort_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned FillW = $clog2(DEPTH + 1);

  q_item_t          mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign ready_o = (fill_q != FillW'(DEPTH));
  assign valid_o = (fill_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill bookkeeping
  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + FillW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// File: design/msort_back.sv
`timescale 1ns / 1ps
`default_nettype none
module msort_back #(
  parameter int unsigned MAX_ELEMENTS = msort_pkg::MaxElementsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           q_valid_i,
  input  msort_pkg::q_item_t                  q_item_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [msort_pkg::DataW-1:0]  sorted_value_o,
  output logic                                is_final_o
);

  import msort_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CntW  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SumW  = CntW + 2;

  back_state_e      state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  a_q, a_d, b_q, b_d, k_q, k_d;
  logic [CntW-1:0]  mid_q, mid_d, hi_q, hi_d, width_q, width_d;
  logic             par_q, par_d;

  logic [DataW-1:0] rd0_a, rd0_b, rd1_a, rd1_b, src_a, src_b, merge_w;
  logic             ram0_we, ram1_we, take_a;
  logic [AddrW-1:0] ram0_waddr;
  logic [DataW-1:0] ram0_wdata;
  logic [CntW-1:0]  a_inc, k_inc;
  logic [SumW-1:0]  w_dbl, run_mid, run_hi, first_w;

  // limit a run bound to the sequence length
  function automatic logic [CntW-1:0] clip(input logic [SumW-1:0] x,
                                           input logic [CntW-1:0] lim);
    logic [CntW-1:0] r;
    if (x > SumW'(lim)) begin
      r = lim;
    end else begin
      r = x[CntW-1:0];
    end
    return r;
  endfunction

  // ping-pong buffers, the source of the current pass selected by par_q
  msort_ram #(.WIDTH(DataW), .DEPTH(MAX_ELEMENTS)) u_ram0 (
    .clk_i     (clk_i),
    .we_i      (ram0_we),
    .waddr_i   (ram0_waddr),
    .wdata_i   (ram0_wdata),
    .raddr_a_i (a_d[AddrW-1:0]),
    .raddr_b_i (b_d[AddrW-1:0]),
    .rdata_a_o (rd0_a),
    .rdata_b_o (rd0_b)
  );

  msort_ram #(.WIDTH(DataW), .DEPTH(MAX_ELEMENTS)) u_ram1 (
    .clk_i     (clk_i),
    .we_i      (ram1_we),
    .waddr_i   (k_q[AddrW-1:0]),
    .wdata_i   (merge_w),
    .raddr_a_i (a_d[AddrW-1:0]),
    .raddr_b_i (b_d[AddrW-1:0]),
    .rdata_a_o (rd1_a),
    .rdata_b_o (rd1_b)
  );

  assign src_a = par_q ? rd1_a : rd0_a;
  assign src_b = par_q ? rd1_b : rd0_b;

  // merge decision: left head wins ties
  assign take_a  = (a_q < mid_q) &&
                   ((b_q >= hi_q) || ($signed(src_a) <= $signed(src_b)));
  assign merge_w = take_a ? src_a : src_b;

  assign q_pop_o    = (state_q == ST_IDLE) && q_valid_i;
  assign ram0_we    = q_pop_o || ((state_q == ST_MERGE) && par_q);
  assign ram0_waddr = (state_q == ST_IDLE) ? cnt_q[AddrW-1:0] : k_q[AddrW-1:0];
  assign ram0_wdata = (state_q == ST_IDLE) ? q_item_i.value : merge_w;
  assign ram1_we    = (state_q == ST_MERGE) && !par_q;

  assign a_inc   = a_q + CntW'(1);
  assign k_inc   = k_q + CntW'(1);
  assign w_dbl   = SumW'({width_q, 1'b0});
  assign run_mid = SumW'(hi_q) + SumW'(width_q);
  assign run_hi  = SumW'(hi_q) + SumW'({width_q, 1'b0});
  assign first_w = SumW'(1);

  // results straight from the registered read of the source buffer
  assign out_valid_o    = (state_q == ST_OUT_SHOW);
  assign sorted_value_o = $signed(src_a);
  assign is_final_o     = (a_inc == cnt_q);

  // sequencer: load, merge passes, then stream out
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    width_d = width_q;
    par_d   = par_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          cnt_d = cnt_q + CntW'(1);
          if (q_item_i.last) begin
            par_d = 1'b0;
            a_d   = '0;
            k_d   = '0;
            if (cnt_q == '0) begin
              state_d = ST_OUT_FETCH;
            end else begin
              width_d = first_w[CntW-1:0];
              mid_d   = clip(first_w, cnt_d);
              b_d     = clip(first_w, cnt_d);
              hi_d    = clip(SumW'(2), cnt_d);
              state_d = ST_SETUP;
            end
          end
        end
      end
      ST_SETUP: begin
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        if (k_inc == hi_q) begin
          if (hi_q == cnt_q) begin
            // pass done: double the run width
            par_d = !par_q;
            a_d   = '0;
            k_d   = '0;
            if (w_dbl >= SumW'(cnt_q)) begin
              state_d = ST_OUT_SHOW;
            end else begin
              width_d = w_dbl[CntW-1:0];
              mid_d   = clip(w_dbl, cnt_q);
              b_d     = clip(w_dbl, cnt_q);
              hi_d    = clip(SumW'({w_dbl, 1'b0}), cnt_q);
              state_d = ST_SETUP;
            end
          end else begin
            // next pair of runs
            a_d   = hi_q;
            mid_d = clip(run_mid, cnt_q);
            b_d   = clip(run_mid, cnt_q);
            hi_d  = clip(run_hi, cnt_q);
            k_d   = k_inc;
          end
        end else begin
          a_d = take_a ? a_inc : a_q;
          b_d = take_a ? b_q : b_q + CntW'(1);
          k_d = k_inc;
        end
      end
      ST_OUT_FETCH: begin
        state_d = ST_OUT_SHOW;
      end
      ST_OUT_SHOW: begin
        if (out_ready_i) begin
          if (a_inc == cnt_q) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            a_d = a_inc;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      par_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      par_q   <= par_d;
    end
  end

  // indexes and run bounds
  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    k_q     <= k_d;
    mid_q   <= mid_d;
    hi_q    <= hi_d;
    width_q <= width_d;
  end

  // a shown result always lies inside the loaded set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT_SHOW) |-> (a_q < cnt_q))
    else $error("result index beyond loaded count");

  // merge cursors stay inside their runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> ((a_q <= mid_q) && (mid_q <= hi_q) && (hi_q <= cnt_q)))
    else $error("merge cursors out of order");

  // the write index never passes the end of the current run pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (k_q < hi_q))
    else $error("merge write index past run end");

  // the final result returns the block to loading with an empty buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && is_final_o) |=> ((state_q == ST_IDLE) && (cnt_q == '0)))
    else $error("sequence not closed after final result");

endmodule
`default_nettype wire

// File: design/merge_sorter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Merge sorter. Values stream in one per item through a short queue and are
// written into a buffer; an item with is_last set, or the item that fills the
// buffer (MAX_ELEMENTS entries), closes the sequence. The set is then sorted
// ascending as signed 32-bit numbers by a bottom-up merge sort that ping-pongs
// between two buffer memories, one merged element per cycle within a pass,
// so a set of n values takes ceil(log2(n)) passes. Results then leave one
// per cycle when the output side is ready, the last one flagged with
// is_final. Loading runs at one item per cycle while the back end is idle;
// the merge is done by a single merge unit with one write per cycle into
// the destination memory. While a set is sorted or streamed out, new items
// wait in the input queue and then stall.
module merge_sorter_core #(
  parameter int unsigned MAX_ELEMENTS = msort_pkg::MaxElementsDef,
  parameter int unsigned QUEUE_DEPTH  = msort_pkg::QueueDepthDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [msort_pkg::DataW-1:0] value_i,
  input  wire logic                               is_last_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [msort_pkg::DataW-1:0]      sorted_value_o,
  output logic                                    is_final_o
);

  import msort_pkg::*;

  logic    push, q_ready, q_valid, q_pop;
  q_item_t push_item, q_item;

  // front: accept and mark the end of each sequence
  msort_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .is_last_i  (is_last_i),
    .push_o     (push),
    .item_o     (push_item),
    .q_ready_i  (q_ready)
  );

  // decoupling queue
  msort_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  // back: store, sort and stream out
  msort_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_o (sorted_value_o),
    .is_final_o     (is_final_o)
  );

endmodule
`default_nettype wire

// File: sim/merge_sorter_core_tb.sv
`timescale 1ns / 1ps
module merge_sorter_core_tb;

  localparam int unsigned SetCap      = msort_pkg::MaxElementsDef;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned RandomItems = 60;

  typedef logic signed [msort_pkg::DataW-1:0] word_t;
  typedef word_t word_q_t[$];

  typedef struct {
    word_t value;
    logic  is_final;
  } sorted_entry_t;

  localparam word_t WordMax = {1'b0, {(msort_pkg::DataW-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(msort_pkg::DataW-1){1'b0}}};

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  word_t value_i     = '0;
  logic  is_last_i   = 1'b0;
  logic  out_ready_i = 1'b0;
  logic  in_ready_o;
  logic  out_valid_o;
  word_t sorted_value_o;
  logic  is_final_o;

  // values of the set being loaded and the sorted results still to come
  word_q_t       open_set;
  sorted_entry_t sorted_expect[$];

  int unsigned fail_count     = 0;
  int unsigned items_sent     = 0;
  int unsigned sets_sorted    = 0;
  int unsigned results_seen   = 0;
  int unsigned idle_cycles    = 0;
  int unsigned rx_wait        = 0;
  bit          full_rate      = 1'b0;

  merge_sorter_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .is_last_i     (is_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_value_o(sorted_value_o),
    .is_final_o    (is_final_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // wait cycles per item, none during full rate stretches
  function automatic int unsigned draw_wait();
    if (full_rate) return 0;
    return $urandom_range(0, 5);
  endfunction

  // value mix: extremes, a narrow band for duplicates, full range
  function automatic word_t draw_value();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? WordMax : WordMin;
      1, 2:    return word_t'($signed($urandom_range(0, 8)) - 4);
      default: return word_t'($urandom);
    endcase
  endfunction

  // ascending insertion sort on signed words
  function automatic word_q_t sort_ascending(word_q_t src);
    word_q_t dst;
    int      j;
    foreach (src[i]) begin
      j = dst.size();
      while (j > 0 && dst[j-1] > src[i]) j--;
      dst.insert(j, src[i]);
    end
    return dst;
  endfunction

  // collect an accepted value; a closed set turns into sorted results
  function automatic void record_item(word_t value, logic last);
    word_q_t ordered;
    open_set.push_back(value);
    items_sent++;
    if (last || open_set.size() == SetCap) begin
      ordered = sort_ascending(open_set);
      foreach (ordered[k]) sorted_expect.push_back('{ordered[k], k == ordered.size() - 1});
      open_set.delete();
      sets_sorted++;
    end
  endfunction

  // drive one item and hold it until the block takes it
  task automatic send_item(input word_t value, input logic last);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    is_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    record_item(value, last);
  endtask

  // send a whole set, is_last on its final item
  task automatic send_set(input word_q_t values);
    foreach (values[i]) send_item(values[i], i == values.size() - 1);
  endtask

  // single value sets at both ends of the range and at zero
  task automatic test_single_value();
    full_rate = 1'b0;
    send_item(WordMin, 1'b1);
    send_item(WordMax, 1'b1);
    send_item('0, 1'b1);
  endtask

  // range limits mixed with duplicates, sent back to back
  task automatic test_extremes();
    full_rate = 1'b1;
    send_set('{WordMax, WordMin, -1, 0, 1, WordMax, WordMin, -1});
    full_rate = 1'b0;
  endtask

  // already ordered, reversed, all equal and a pair
  task automatic test_ordered_runs();
    send_set('{WordMin, -7, 3, WordMax});
    send_set('{WordMax, 100, -100, WordMin});
    send_set('{42, 42, 42});
    send_set('{5, -5});
  endtask

  // a set that fills the buffer without is_last closes itself
  task automatic test_buffer_full();
    for (int i = 0; i < SetCap; i++) begin
      full_rate = (i >= SetCap / 2);
      send_item(draw_value(), 1'b0);
    end
    full_rate = 1'b0;
  endtask

  // random sets, mostly short, some long, a few at full size
  task automatic test_random_sets();
    int unsigned len;
    int unsigned sent;
    sent = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(0, 19))
        0:       len = SetCap;
        1, 2:    len = $urandom_range(13, 40);
        default: len = $urandom_range(1, 12);
      endcase
      full_rate = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) send_item(draw_value(), i == len - 1);
      sent += len;
    end
    full_rate = 1'b0;
  endtask

  // receiver: random stalls, each result checked against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wait = 0;
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (sorted_expect.size() == 0) begin
          $error("result with nothing expected: sorted_value=%0d is_final=%0b",
                 sorted_value_o, is_final_o);
          fail_count++;
        end else begin
          if (sorted_value_o !== sorted_expect[0].value) begin
            $error("sorted_value mismatch: expected %0d, got %0d",
                   sorted_expect[0].value, sorted_value_o);
            fail_count++;
          end
          if (is_final_o !== sorted_expect[0].is_final) begin
            $error("is_final mismatch: expected %0b, got %0b",
                   sorted_expect[0].is_final, is_final_o);
            fail_count++;
          end
          void'(sorted_expect.pop_front());
        end
        rx_wait = draw_wait();
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_ready_i <= (rx_wait == 0);
    end
  end

  // watchdog on cycles without any accepted item or result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("timeout after %0d cycles without progress", StallLimit);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // test sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_single_value();
    test_extremes();
    test_ordered_runs();
    test_buffer_full();
    test_random_sets();
    in_valid_i <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d items in %0d sets, checked %0d sorted results",
             items_sent, sets_sorted, results_seen);
    $display("sets covered single values, range limits, duplicates and a full buffer");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/msort_pkg.sv
design/msort_ram.sv
design/msort_front.sv
design/msort_queue.sv
design/msort_back.sv
design/merge_sorter_core.sv
sim/merge_sorter_core_tb.sv
